FILE: hw/rtl/u8esc_pkg.sv
// ----------------------------------------------------------------------------
// u8esc_pkg
// Shared types, constants and helpers for the UTF-8 string escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package u8esc_pkg;

  localparam int unsigned MaxOut = 12;
  localparam int unsigned CntW   = 4;
  localparam int unsigned PADDR_W = 3;

  localparam logic [0:0] REG_ASCII_ONLY = 1'b0;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [7:0] C0_BS = 8'h08;
  localparam logic [7:0] C0_HT = 8'h09;
  localparam logic [7:0] C0_LF = 8'h0A;
  localparam logic [7:0] C0_FF = 8'h0C;
  localparam logic [7:0] C0_CR = 8'h0D;

  localparam logic [15:0] SURR_HI   = 16'hD800;
  localparam logic [15:0] SURR_LO   = 16'hDC00;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [15:0][7:0] HEX_TAB = "FEDCBA9876543210";

  typedef struct packed {
    logic [7:0] in_byte;
    logic       single_quotes;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  typedef logic [5:0][7:0] u16_esc_t;

  typedef struct packed {
    logic [MaxOut-1:0][7:0] chars;
    logic [CntW-1:0]        count;
    logic                   last;
  } esc_res_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return HEX_TAB[d];
  endfunction

  // \uXXXX, backslash first
  function automatic u16_esc_t u16_esc(input logic [15:0] v);
    u16_esc_t r;
    r[0] = CH_BSLASH;
    r[1] = CH_U;
    r[2] = hex_char(v[15:12]);
    r[3] = hex_char(v[11:8]);
    r[4] = hex_char(v[7:4]);
    r[5] = hex_char(v[3:0]);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/utf8_string_escaper.sv
// Flow: an accepted byte is registered at the input; its escaped bytes are loaded into the output register when free.
// Throughput: one input transaction per cycle while each gives at most one byte and
// the output is not stalled; an item giving more bytes holds the input until the output
// register has sent them, one byte per transaction (up to 12 for a surrogate pair).
// Reset: asynchronous, active low; clears the open sequence, both valid flags and
// the ASCII-only bit. No clearing pass is needed.
// ----------------------------------------------------------------------------
// utf8_string_escaper
// Escapes a byte stream of string text, gathering UTF-8 sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_string_escaper (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire u8esc_pkg::in_item_t           in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output u8esc_pkg::out_item_t               out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [u8esc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import u8esc_pkg::*;

  in_item_t in_q, in_d;
  logic     in_vld_q, in_vld_d;
  logic     ascii_only;
  logic     free;
  logic     step;
  logic     accept;
  esc_res_t res;

  assign step       = in_vld_q && free;
  assign in_stall_o = in_vld_q && !free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_d     = in_q;
    in_vld_d = in_vld_q;
    if (accept) begin
      in_d     = in_data_i;
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  u8esc_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .ascii_only_o (ascii_only)
  );

  u8esc_encode u_encode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (in_q),
    .ascii_only_i (ascii_only),
    .advance_i    (step),
    .res_o        (res)
  );

  u8esc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .load_i      (step),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/u8esc_cfg.sv
// ----------------------------------------------------------------------------
// u8esc_cfg
// APB register file holding the ASCII-only control bit.
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [u8esc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output logic                               ascii_only_o
);
  import u8esc_pkg::*;

  logic ensure_q, ensure_d;
  logic sel_reg;
  logic wr;

  assign sel_reg = (paddr[PADDR_W-1:PADDR_W-1] == REG_ASCII_ONLY);
  assign wr      = psel && penable && pwrite && sel_reg;
  assign ensure_d = wr ? pwdata[0] : ensure_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ensure_q <= 1'b0;
    end else begin
      ensure_q <= ensure_d;
    end
  end

  assign prdata       = sel_reg ? {31'b0, ensure_q} : 32'b0;
  assign pready       = 1'b1;
  assign ascii_only_o = ensure_q;

endmodule

`default_nettype wire

FILE: hw/rtl/u8esc_encode.sv
// ----------------------------------------------------------------------------
// u8esc_encode
// Sequence state and escape generation for one registered input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_encode (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire u8esc_pkg::in_item_t  item_i,
  input  wire logic                 ascii_only_i,
  input  wire logic                 advance_i,
  output u8esc_pkg::esc_res_t       res_o
);
  import u8esc_pkg::*;

  logic [7:0] pend_q [3];
  logic [7:0] pend_d [3];
  logic [1:0] pcount_q, pcount_d;
  logic [2:0] slen_q, slen_d;

  logic [7:0]             b;
  logic [7:0]             quote;
  logic                   last;
  logic                   open;
  logic                   cont;
  logic                   complete;
  logic [2:0]             lead_len;
  u16_esc_t               fs;
  logic [2:0]             fn;
  logic                   fhold;
  logic [20:0]            cp;
  logic [20:0]            supp;
  logic [15:0]            hi;
  logic [15:0]            lo;
  logic [MaxOut-1:0][7:0] s;
  logic [CntW-1:0]        ns;
  logic [1:0]             npre;

  always_comb begin
    b     = item_i.in_byte;
    quote = item_i.single_quotes ? CH_APOS : CH_DQUOTE;
    last  = item_i.in_last;
    open  = (slen_q != 3'd0) && (pcount_q != 2'd0);
    cont  = (b[7:6] == 2'b10);
    complete = open && cont && (({1'b0, pcount_q} + 3'd1) >= slen_q);

    if (b[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end

    // byte that does not continue an open sequence
    fs    = '0;
    fn    = 3'd0;
    fhold = 1'b0;
    if (b == quote || b == CH_BSLASH) begin
      fs[0] = CH_BSLASH;
      fs[1] = b;
      fn    = 3'd2;
    end else if (b < 8'h20) begin
      fs[0] = CH_BSLASH;
      fn    = 3'd2;
      case (b)
        C0_BS:   fs[1] = CH_B;
        C0_FF:   fs[1] = CH_F;
        C0_LF:   fs[1] = CH_N;
        C0_CR:   fs[1] = CH_R;
        C0_HT:   fs[1] = CH_T;
        default: begin
          fs = u16_esc({8'h00, b});
          fn = 3'd6;
        end
      endcase
    end else if (!b[7]) begin
      fs[0] = b;
      fn    = 3'd1;
    end else if (lead_len != 3'd0 && !last) begin
      fhold = 1'b1;
    end else begin
      fs[0] = b;
      fn    = 3'd1;
    end

    // code point assembly
    case (slen_q)
      3'd2:    cp = {16'b0, pend_q[0][4:0]};
      3'd3:    cp = {17'b0, pend_q[0][3:0]};
      default: cp = {18'b0, pend_q[0][2:0]};
    endcase
    if (pcount_q >= 2'd2) begin
      cp = {cp[14:0], pend_q[1][5:0]};
    end
    if (pcount_q == 2'd3) begin
      cp = {cp[14:0], pend_q[2][5:0]};
    end
    cp   = {cp[14:0], b[5:0]};
    supp = cp - SUPP_BASE;
    hi   = SURR_HI + {5'b0, supp[20:10]};
    lo   = SURR_LO + {6'b0, supp[9:0]};

    s    = '0;
    ns   = '0;
    npre = 2'd0;
    if (open && cont) begin
      if (complete && ascii_only_i) begin
        if (cp[20:16] == 5'd0) begin
          s[5:0] = u16_esc(cp[15:0]);
          ns     = 4'd6;
        end else begin
          s[5:0]  = u16_esc(hi);
          s[11:6] = u16_esc(lo);
          ns      = 4'd12;
        end
      end else if (complete || last) begin
        npre = pcount_q;
        s[0] = b;
        ns   = 4'd1;
      end
    end else begin
      if (open) begin
        npre = pcount_q;
      end
      s[5:0] = fs;
      ns     = {1'b0, fn};
    end

    case (npre)
      2'd0:    res_o.chars = s;
      2'd1:    res_o.chars = {s[10:0], pend_q[0]};
      2'd2:    res_o.chars = {s[9:0], pend_q[1], pend_q[0]};
      2'd3:    res_o.chars = {s[8:0], pend_q[2], pend_q[1], pend_q[0]};
      default: res_o.chars = s;
    endcase
    res_o.count = {2'b00, npre} + ns;
    res_o.last  = last;

    pend_d   = pend_q;
    pcount_d = 2'd0;
    slen_d   = 3'd0;
    if (open && cont) begin
      if (!complete && !last) begin
        pend_d[pcount_q] = b;
        pcount_d         = pcount_q + 2'd1;
        slen_d           = slen_q;
      end
    end else if (fhold) begin
      pend_d[0] = b;
      pcount_d  = 2'd1;
      slen_d    = lead_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= 2'd0;
      slen_q   <= 3'd0;
    end else if (advance_i) begin
      pcount_q <= pcount_d;
      slen_q   <= slen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/u8esc_outbuf.sv
// ----------------------------------------------------------------------------
// u8esc_outbuf
// Result register; sends the escaped bytes of one item one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_outbuf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire u8esc_pkg::esc_res_t  res_i,
  input  wire logic                 load_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output u8esc_pkg::out_item_t      out_data_o
);
  import u8esc_pkg::*;

  logic [MaxOut-1:0][7:0] chars_q, chars_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic                   last_q, last_d;
  logic                   has;
  logic                   take;
  logic                   done;
  logic                   at_end;

  always_comb begin
    has    = (count_q != '0);
    at_end = (idx_q == count_q - 4'd1);
    take   = has && !out_stall_i;
    done   = take && at_end;
    free_o = !has || done;

    chars_d = chars_q;
    count_d = count_q;
    idx_d   = idx_q;
    last_d  = last_q;
    if (load_i && res_i.count != '0) begin
      chars_d = res_i.chars;
      count_d = res_i.count;
      idx_d   = '0;
      last_d  = res_i.last;
    end else if (done) begin
      count_d = '0;
      idx_d   = '0;
    end else if (take) begin
      idx_d = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
    last_q  <= last_d;
  end

  assign out_valid_o         = has;
  assign out_data_o.out_char = chars_q[idx_q];
  assign out_data_o.out_last = last_q && at_end;

endmodule

`default_nettype wire

FILE: hw/rtl/u8esc_checker.sv
// ----------------------------------------------------------------------------
// u8esc_checker
// Port-level checks for the string escaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire u8esc_pkg::out_item_t          out_data_o,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [u8esc_pkg::PADDR_W-1:0] paddr,
  input wire logic [31:0]                   pwdata,
  input wire logic [31:0]                   prdata,
  input wire logic                          pready
);
  import u8esc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[PADDR_W-1:PADDR_W-1] == REG_ASCII_ONLY)
    ##1 (paddr[PADDR_W-1:PADDR_W-1] == REG_ASCII_ONLY)
    |-> prdata[0] == $past(pwdata[0]))
    else $error("ASCII-only bit read back differs from write");

endmodule

bind utf8_string_escaper u8esc_checker u_u8esc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

`default_nettype wire
